// ===== hw/rtl/mcoc_pkg.sv =====
// Shared types, constants and helpers of the matrix chain order cost block.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package mcoc_pkg;

  localparam int unsigned MaxMatricesDef = 16;
  localparam int unsigned DimBitsDef     = 10;

  localparam int unsigned DimFieldW = 10;   // dimension field on the input stream
  localparam int unsigned InDataW   = 16;   // input tdata, padded to bytes
  localparam int unsigned CostW     = 48;
  localparam int unsigned SplitW    = 4;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned OutDataW  = 56;   // cost + split + status, padded to bytes

  localparam logic [CostW-1:0] CostMax = '1;

  typedef enum logic [StatusW-1:0] {
    StOk        = 2'd0,
    StTooFew    = 2'd1,
    StTooMany   = 2'd2,
    StSaturated = 2'd3
  } status_e;

  typedef struct packed {
    logic [CostW-1:0]  min_cost;
    logic [SplitW-1:0] top_split;
    status_e           status;
  } result_t;

  typedef enum logic [3:0] {
    CtlIdle,
    CtlIvA,
    CtlIvB,
    CtlIvC,
    CtlRead,
    CtlMul,
    CtlMul2,
    CtlCmp,
    CtlWrite,
    CtlFin,
    CtlDone
  } ctl_state_e;

  // Saturating add: all ones absorbs everything.
  function automatic logic [CostW-1:0] sat_add(input logic [CostW-1:0] a,
                                               input logic [CostW-1:0] b);
    logic [CostW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if ((a == CostMax) || (b == CostMax) || (s >= {1'b0, CostMax})) begin
      return CostMax;
    end
    return s[CostW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/matrix_chain_order_cost.sv =====
// Top level of the matrix chain order cost block: stream front end, dimension
// store, interval tables and sequencer. Depends on mcoc_pkg and all mcoc_* modules.
`default_nettype none

// The block takes the dimension list p[0..n] of a chain of n matrices, one
// dimension per input transfer, and the transfer with tlast set closes the list.
// Non-final dimensions are taken one per cycle while no run is in progress,
// also while a result waits on the output. On the final dimension the block
// answers with one result transfer carrying the minimal scalar multiplication
// count (saturated at all ones), the outermost split index and a status code.
// Lists of one dimension (status too few), of more than MAX_MATRICES+1
// dimensions (status too many, extra dimensions dropped) or of two dimensions
// are answered in the next cycle. Longer lists run the interval program from
// the tables in memory: each split point passes through table read, sum and
// first product, second product and compare; each interval first fetches its
// outer dimensions and ends with one write. The input stalls for the whole
// run. A final dimension is held off while a previous result is still
// waiting to be taken.
module matrix_chain_order_cost #(
  parameter int unsigned MAX_MATRICES = mcoc_pkg::MaxMatricesDef,
  parameter int unsigned DIM_BITS     = mcoc_pkg::DimBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [mcoc_pkg::InDataW-1:0]  s_axis_tdata,   // [9:0] dimension
  input  wire logic                          s_axis_tlast,   // is_last
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [mcoc_pkg::OutDataW-1:0] m_axis_tdata    // [47:0] min_cost,
                                                             // [51:48] top_split,
                                                             // [53:52] status
);

  localparam int unsigned DimDepth  = MAX_MATRICES + 1;
  localparam int unsigned CountOver = MAX_MATRICES + 2;
  localparam int unsigned CW        = $clog2(MAX_MATRICES + 3);
  localparam int unsigned DAW       = $clog2(DimDepth);
  localparam int unsigned NW        = $clog2(MAX_MATRICES + 1);
  localparam int unsigned IW        = $clog2(MAX_MATRICES);

  // Input side
  logic          in_xfer, store_en;
  logic [CW-1:0] count_q, count_d, d_total, n_full;
  logic [mcoc_pkg::DimFieldW+DIM_BITS-1:0] dim_ext;
  logic [DIM_BITS-1:0] dim_wdata;

  // Result side
  logic              busy_q, busy_d, out_valid_q, out_valid_d;
  mcoc_pkg::result_t out_q, out_d, quick_res;
  logic              quick_ld, start;

  // Sequencer and memories
  logic                       ctl_done;
  mcoc_pkg::result_t          ctl_res;
  logic [DAW-1:0]             dim_raddr;
  logic [DIM_BITS-1:0]        dim_rdata;
  logic                       tbl_we;
  logic [2*IW-1:0]            tbl_waddr, tbl_raddr_a, tbl_raddr_b, tbl_split_raddr;
  logic [mcoc_pkg::CostW-1:0] tbl_cost_wdata, tbl_cost_rdata_a, tbl_cost_rdata_b;
  logic [IW-1:0]              tbl_split_wdata, tbl_split_rdata;

  // Hold a final dimension back until the output register is free.
  assign s_axis_tready = !busy_q && (!out_valid_q || !s_axis_tlast);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign store_en      = in_xfer && (count_q < CW'(DimDepth));

  // Count as the list would stand after this transfer; an overflowed list
  // parks one above the store depth.
  assign d_total = store_en ? (count_q + CW'(1)) : CW'(CountOver);
  assign n_full  = d_total - CW'(1);

  assign dim_ext   = {{DIM_BITS{1'b0}}, s_axis_tdata[mcoc_pkg::DimFieldW-1:0]};
  assign dim_wdata = dim_ext[DIM_BITS-1:0];

  always_comb begin
    count_d = count_q;
    if (in_xfer) begin
      count_d = s_axis_tlast ? '0 : d_total;
    end
  end

  // Decide between an answer right away and a run of the sequencer.
  always_comb begin
    quick_ld            = 1'b0;
    start               = 1'b0;
    quick_res.min_cost  = '0;
    quick_res.top_split = '0;
    quick_res.status    = mcoc_pkg::StOk;
    if (in_xfer && s_axis_tlast) begin
      if (d_total < CW'(2)) begin
        quick_ld         = 1'b1;
        quick_res.status = mcoc_pkg::StTooFew;
      end else if (d_total > CW'(DimDepth)) begin
        quick_ld         = 1'b1;
        quick_res.status = mcoc_pkg::StTooMany;
      end else if (d_total == CW'(2)) begin
        quick_ld = 1'b1;
      end else begin
        start = 1'b1;
      end
    end
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (start) begin
      busy_d = 1'b1;
    end
    if (quick_ld) begin
      out_valid_d = 1'b1;
      out_d       = quick_res;
    end else if (ctl_done) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      out_d       = ctl_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.status, out_q.top_split, out_q.min_cost};

  mcoc_dim_mem #(
    .DEPTH (DimDepth),
    .WIDTH (DIM_BITS)
  ) u_dim_mem (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (count_q[DAW-1:0]),
    .wdata_i (dim_wdata),
    .raddr_i (dim_raddr),
    .rdata_o (dim_rdata)
  );

  mcoc_table_mem #(
    .IW (IW)
  ) u_table_mem (
    .clk_i          (clk_i),
    .we_i           (tbl_we),
    .waddr_i        (tbl_waddr),
    .cost_wdata_i   (tbl_cost_wdata),
    .split_wdata_i  (tbl_split_wdata),
    .cost_raddr_a_i (tbl_raddr_a),
    .cost_raddr_b_i (tbl_raddr_b),
    .split_raddr_i  (tbl_split_raddr),
    .cost_rdata_a_o (tbl_cost_rdata_a),
    .cost_rdata_b_o (tbl_cost_rdata_b),
    .split_rdata_o  (tbl_split_rdata)
  );

  mcoc_ctrl #(
    .MAX_MATRICES (MAX_MATRICES),
    .DIM_BITS     (DIM_BITS)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .n_i                (n_full[NW-1:0]),
    .done_o             (ctl_done),
    .result_o           (ctl_res),
    .dim_raddr_o        (dim_raddr),
    .dim_rdata_i        (dim_rdata),
    .tbl_we_o           (tbl_we),
    .tbl_waddr_o        (tbl_waddr),
    .tbl_cost_wdata_o   (tbl_cost_wdata),
    .tbl_split_wdata_o  (tbl_split_wdata),
    .tbl_cost_raddr_a_o (tbl_raddr_a),
    .tbl_cost_raddr_b_o (tbl_raddr_b),
    .tbl_split_raddr_o  (tbl_split_raddr),
    .tbl_cost_rdata_a_i (tbl_cost_rdata_a),
    .tbl_cost_rdata_b_i (tbl_cost_rdata_b),
    .tbl_split_rdata_i  (tbl_split_rdata)
  );

  a_last_finds_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast) |-> !out_valid_q)
    else $error("final dimension taken while a result is pending");

  a_done_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_done |-> (busy_q && !out_valid_q))
    else $error("sequencer result without a run in progress");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CountOver))
    else $error("dimension count beyond overflow mark");

endmodule

`default_nettype wire

// ===== hw/rtl/mcoc_dim_mem.sv =====
// Dimension store: one write port, one read port with registered data.
// Depends on mcoc_pkg for default widths.
`default_nettype none

module mcoc_dim_mem #(
  parameter int unsigned DEPTH = mcoc_pkg::MaxMatricesDef + 1,
  parameter int unsigned WIDTH = mcoc_pkg::DimBitsDef,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mcoc_table_mem.sv =====
// Interval tables: cost memory (two read ports) and split memory (one read
// port), written together at one address. Depends on mcoc_pkg.
`default_nettype none

module mcoc_table_mem #(
  parameter int unsigned IW  = $clog2(mcoc_pkg::MaxMatricesDef),
  localparam int unsigned AW = 2 * IW
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [mcoc_pkg::CostW-1:0] cost_wdata_i,
  input  wire logic [IW-1:0]              split_wdata_i,
  input  wire logic [AW-1:0]              cost_raddr_a_i,
  input  wire logic [AW-1:0]              cost_raddr_b_i,
  input  wire logic [AW-1:0]              split_raddr_i,
  output logic      [mcoc_pkg::CostW-1:0] cost_rdata_a_o,
  output logic      [mcoc_pkg::CostW-1:0] cost_rdata_b_o,
  output logic      [IW-1:0]              split_rdata_o
);

  logic [mcoc_pkg::CostW-1:0] cost_mem  [2**AW];
  logic [IW-1:0]              split_mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      cost_mem[waddr_i] <= cost_wdata_i;
    end
    cost_rdata_a_o <= cost_mem[cost_raddr_a_i];
    cost_rdata_b_o <= cost_mem[cost_raddr_b_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      split_mem[waddr_i] <= split_wdata_i;
    end
    split_rdata_o <= split_mem[split_raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mcoc_ctrl.sv =====
// Interval sequencer: walks chain lengths, intervals and split points, reads
// the dimension store and the tables, writes each interval's best cost back.
// Depends on mcoc_pkg.
`default_nettype none

module mcoc_ctrl #(
  parameter int unsigned MAX_MATRICES = mcoc_pkg::MaxMatricesDef,
  parameter int unsigned DIM_BITS     = mcoc_pkg::DimBitsDef,
  localparam int unsigned IW  = $clog2(MAX_MATRICES),
  localparam int unsigned NW  = $clog2(MAX_MATRICES + 1),
  localparam int unsigned DAW = $clog2(MAX_MATRICES + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [NW-1:0]              n_i,
  output logic                            done_o,
  output mcoc_pkg::result_t               result_o,
  output logic      [DAW-1:0]             dim_raddr_o,
  input  wire logic [DIM_BITS-1:0]        dim_rdata_i,
  output logic                            tbl_we_o,
  output logic      [2*IW-1:0]            tbl_waddr_o,
  output logic      [mcoc_pkg::CostW-1:0] tbl_cost_wdata_o,
  output logic      [IW-1:0]              tbl_split_wdata_o,
  output logic      [2*IW-1:0]            tbl_cost_raddr_a_o,
  output logic      [2*IW-1:0]            tbl_cost_raddr_b_o,
  output logic      [2*IW-1:0]            tbl_split_raddr_o,
  input  wire logic [mcoc_pkg::CostW-1:0] tbl_cost_rdata_a_i,
  input  wire logic [mcoc_pkg::CostW-1:0] tbl_cost_rdata_b_i,
  input  wire logic [IW-1:0]              tbl_split_rdata_i
);

  mcoc_pkg::ctl_state_e state_q, state_d;

  logic [IW-1:0]              len_q, i_q, j_q, k_q, last_q, where_q;
  logic [DIM_BITS-1:0]        di_q, dj1_q;
  logic [mcoc_pkg::CostW-1:0] sum_q, best_q;
  logic [2*DIM_BITS-1:0]      prod1_q;
  logic [3*DIM_BITS-1:0]      prod_q;

  logic [NW-1:0]              n_m1;
  logic [mcoc_pkg::CostW-1:0] cost_a, cost_b, cand;
  logic                       split_end;
  logic [IW+mcoc_pkg::SplitW-1:0] split_ext;

  assign n_m1      = n_i - NW'(1);
  assign split_end = ((k_q + IW'(1)) == j_q);

  // Diagonal entries are zero and never stored.
  assign cost_a = (k_q == i_q) ? '0 : tbl_cost_rdata_a_i;
  assign cost_b = ((k_q + IW'(1)) == j_q) ? '0 : tbl_cost_rdata_b_i;
  assign cand   = mcoc_pkg::sat_add(sum_q, mcoc_pkg::CostW'(prod_q));

  assign tbl_cost_raddr_a_o = {i_q, k_q};
  assign tbl_cost_raddr_b_o = {k_q + IW'(1), j_q};
  assign tbl_split_raddr_o  = {IW'(0), last_q};
  assign tbl_waddr_o        = {i_q, j_q};
  assign tbl_cost_wdata_o   = best_q;
  assign tbl_split_wdata_o  = where_q;

  assign split_ext = {{mcoc_pkg::SplitW{1'b0}}, tbl_split_rdata_i};

  always_comb begin
    result_o.min_cost  = best_q;
    result_o.top_split = split_ext[mcoc_pkg::SplitW-1:0];
    result_o.status    = (best_q == mcoc_pkg::CostMax) ? mcoc_pkg::StSaturated
                                                       : mcoc_pkg::StOk;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcoc_pkg::CtlIdle:  if (start_i) state_d = mcoc_pkg::CtlIvA;
      mcoc_pkg::CtlIvA:   state_d = mcoc_pkg::CtlIvB;
      mcoc_pkg::CtlIvB:   state_d = mcoc_pkg::CtlIvC;
      mcoc_pkg::CtlIvC:   state_d = mcoc_pkg::CtlRead;
      mcoc_pkg::CtlRead:  state_d = mcoc_pkg::CtlMul;
      mcoc_pkg::CtlMul:   state_d = mcoc_pkg::CtlMul2;
      mcoc_pkg::CtlMul2:  state_d = mcoc_pkg::CtlCmp;
      mcoc_pkg::CtlCmp:   state_d = split_end ? mcoc_pkg::CtlWrite : mcoc_pkg::CtlRead;
      mcoc_pkg::CtlWrite: begin
        if ((j_q == last_q) && (len_q == last_q)) begin
          state_d = mcoc_pkg::CtlFin;
        end else begin
          state_d = mcoc_pkg::CtlIvA;
        end
      end
      mcoc_pkg::CtlFin:   state_d = mcoc_pkg::CtlDone;
      mcoc_pkg::CtlDone:  state_d = mcoc_pkg::CtlIdle;
      default:            state_d = mcoc_pkg::CtlIdle;
    endcase
  end

  always_comb begin
    done_o      = 1'b0;
    tbl_we_o    = 1'b0;
    dim_raddr_o = DAW'(k_q) + DAW'(1);
    unique case (state_q)
      mcoc_pkg::CtlIvA:   dim_raddr_o = DAW'(i_q);
      mcoc_pkg::CtlIvB:   dim_raddr_o = DAW'(j_q) + DAW'(1);
      mcoc_pkg::CtlWrite: tbl_we_o = 1'b1;
      mcoc_pkg::CtlDone:  done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcoc_pkg::CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers; only one split step is in flight, so a table write
  // always lands before the next read of any entry.
  always_ff @(posedge clk_i) begin
    case (state_q)
      mcoc_pkg::CtlIdle: begin
        len_q  <= IW'(1);
        i_q    <= '0;
        last_q <= n_m1[IW-1:0];
      end
      mcoc_pkg::CtlIvA: begin
        j_q     <= i_q + len_q;
        k_q     <= i_q;
        best_q  <= mcoc_pkg::CostMax;
        where_q <= i_q;
      end
      mcoc_pkg::CtlIvB: di_q  <= dim_rdata_i;
      mcoc_pkg::CtlIvC: dj1_q <= dim_rdata_i;
      mcoc_pkg::CtlMul: begin
        sum_q   <= mcoc_pkg::sat_add(cost_a, cost_b);
        prod1_q <= di_q * dim_rdata_i;
      end
      mcoc_pkg::CtlMul2: prod_q <= prod1_q * dj1_q;
      mcoc_pkg::CtlCmp: begin
        if (cand < best_q) begin
          best_q  <= cand;
          where_q <= k_q;
        end
        if (!split_end) begin
          k_q <= k_q + IW'(1);
        end
      end
      mcoc_pkg::CtlWrite: begin
        if (j_q == last_q) begin
          len_q <= len_q + IW'(1);
          i_q   <= '0;
        end else begin
          i_q <= i_q + IW'(1);
        end
      end
      default: ;
    endcase
  end

  a_split_in_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mcoc_pkg::CtlRead) |-> ((k_q >= i_q) && (k_q < j_q)))
    else $error("split index outside its interval");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == mcoc_pkg::CtlIdle))
    else $error("start while the sequencer is busy");

endmodule

`default_nettype wire

// ===== tb/matrix_chain_order_cost_test.sv =====
// Self-checking bench for matrix_chain_order_cost: sends dimension lists over the input
// stream and checks every result transfer against a built-in interval program.
// Depends on mcoc_pkg and the RTL of the block.

module matrix_chain_order_cost_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CostW      = mcoc_pkg::CostW;
  localparam int unsigned SplitW     = mcoc_pkg::SplitW;
  localparam int unsigned StatusW    = mcoc_pkg::StatusW;
  localparam int unsigned DimFieldW  = mcoc_pkg::DimFieldW;
  localparam int unsigned InDataW    = mcoc_pkg::InDataW;
  localparam int unsigned OutDataW   = mcoc_pkg::OutDataW;
  localparam int unsigned ChainMax   = mcoc_pkg::MaxMatricesDef;
  localparam int unsigned DimSlots   = ChainMax + 1;
  localparam int unsigned ItemTarget = 1050;
  // A full chain stalls the input while it runs; add the longest receiver
  // hold-off and sender gap and take that several times over.
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainWait  = 50;

  // One row of the directed table. When typed is set, want is the result that the
  // row's final dimension must produce; otherwise the chain model decides.
  typedef struct packed {
    logic [DimFieldW-1:0] dim;
    logic                 last;
    logic [4:0]           reps;
    logic                 typed;
    mcoc_pkg::result_t    want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  // Chain model state: the dimension list being collected and its length.
  logic [DimFieldW-1:0] chain_dims [DimSlots];
  int unsigned          dims_seen;

  mcoc_pkg::result_t pending_results [$];
  stim_row_t         stim_rows [$];
  int unsigned       mismatches;
  int unsigned       items_sent;
  bit                quiet;          // suppress idling on both sides
  int unsigned       sink_hold_req;  // long receiver hold-off, consumed by the sink

  matrix_chain_order_cost dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Saturating cost add: anything reaching all ones sticks there.
  function automatic logic [CostW-1:0] cost_sum(input logic [CostW-1:0] a,
                                                input logic [CostW-1:0] b);
    logic [CostW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s[CostW] || (&s[CostW-1:0])) ? mcoc_pkg::CostMax : s[CostW-1:0];
  endfunction

  // Take one dimension into the chain model; on the final one run the interval
  // program over all chain lengths and split points and produce the result.
  task automatic predict_chain(input logic [DimFieldW-1:0] dim, input bit last,
                               output bit emits, output mcoc_pkg::result_t res);
    logic [CostW-1:0]  span_cost  [ChainMax][ChainMax];
    logic [SplitW-1:0] span_split [ChainMax][ChainMax];
    logic [CostW-1:0]  best;
    logic [CostW-1:0]  cand;
    logic [CostW-1:0]  prod;
    logic [SplitW-1:0] best_k;
    int unsigned       count;
    int unsigned       n;
    int unsigned       span;
    int unsigned       i;
    int unsigned       k;
    emits = 1'b0;
    res.min_cost  = '0;
    res.top_split = '0;
    res.status    = mcoc_pkg::StOk;
    // Keep the first DimSlots dimensions; one count above marks an overflowed list.
    if (dims_seen < DimSlots) begin
      chain_dims[dims_seen] = dim;
      dims_seen++;
    end else begin
      dims_seen = DimSlots + 1;
    end
    if (!last) return;
    emits     = 1'b1;
    count     = dims_seen;
    dims_seen = 0;
    if (count < 2) begin
      res.status = mcoc_pkg::StTooFew;
    end else if (count > DimSlots) begin
      res.status = mcoc_pkg::StTooMany;
    end else begin
      n = count - 1;
      for (i = 0; i < n; i++) begin
        span_cost[i][i]  = '0;
        span_split[i][i] = SplitW'(i);
      end
      for (span = 1; span < n; span++) begin
        for (i = 0; i + span < n; i++) begin
          // Start from infinity; a saturated candidate never beats it, and ties
          // keep the earliest split.
          best   = mcoc_pkg::CostMax;
          best_k = SplitW'(i);
          for (k = i; k < i + span; k++) begin
            prod = CostW'(chain_dims[i]) * CostW'(chain_dims[k + 1]) *
                   CostW'(chain_dims[i + span + 1]);
            cand = cost_sum(cost_sum(span_cost[i][k], span_cost[k + 1][i + span]), prod);
            if (cand < best) begin
              best   = cand;
              best_k = SplitW'(k);
            end
          end
          span_cost[i][i + span]  = best;
          span_split[i][i + span] = best_k;
        end
      end
      res.min_cost  = span_cost[0][n - 1];
      res.top_split = (n > 1) ? span_split[0][n - 1] : '0;
      if (res.min_cost == mcoc_pkg::CostMax) res.status = mcoc_pkg::StSaturated;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Idle length for either side: mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  // Offer one dimension after a random gap, hold it until the transfer, then feed
  // it to the chain model. A typed row supplies its own expected result.
  task automatic send_dim(input logic [DimFieldW-1:0] dim, input bit last,
                          input bit typed, input mcoc_pkg::result_t want);
    int unsigned       gap;
    bit                emits;
    mcoc_pkg::result_t got;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(dim);
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    items_sent++;
    predict_chain(dim, last, emits, got);
    if (emits) pending_results.push_back(typed ? want : got);
  endtask

  task automatic add_row(input logic [DimFieldW-1:0] dim, input bit last,
                         input int unsigned reps, input bit typed,
                         input logic [CostW-1:0] cost, input logic [SplitW-1:0] split,
                         input mcoc_pkg::status_e st);
    stim_row_t row;
    row.dim            = dim;
    row.last           = last;
    row.reps           = 5'(reps);
    row.typed          = typed;
    row.want.min_cost  = cost;
    row.want.top_split = split;
    row.want.status    = st;
    stim_rows.push_back(row);
  endtask

  // Result side: check each transfer against the oldest expectation, then pick the
  // ready level for the next cycle. A long hold-off request overrides the gaps.
  initial begin : result_sink
    int unsigned       hold;
    mcoc_pkg::result_t want;
    hold          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, data %h", m_axis_tdata));
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[CostW-1:0] !== want.min_cost)
            report_mismatch($sformatf("min_cost %0d, expected %0d",
                                      m_axis_tdata[CostW-1:0], want.min_cost));
          if (m_axis_tdata[CostW+SplitW-1:CostW] !== want.top_split)
            report_mismatch($sformatf("top_split %0d, expected %0d",
                                      m_axis_tdata[CostW+SplitW-1:CostW], want.top_split));
          if (m_axis_tdata[CostW+SplitW+StatusW-1:CostW+SplitW] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      m_axis_tdata[CostW+SplitW+StatusW-1:CostW+SplitW],
                                      want.status));
        end
      end
      if (sink_hold_req != 0) begin
        hold          = sink_hold_req;
        sink_hold_req = 0;
      end else if (hold == 0 && $urandom_range(3) == 0) begin
        hold = pick_gap();
      end
      if (hold != 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stop the run when no transfer happens on either side for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
          (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no transfer for %0d cycles, %0d results outstanding",
             StallLimit, pending_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned          row_idx;
    int unsigned          rep;
    int unsigned          list_no;
    int unsigned          len;
    int unsigned          i;
    int unsigned          r;
    logic [DimFieldW-1:0] dim;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    quiet         = 1'b0;
    sink_hold_req = 0;
    mismatches    = 0;
    items_sent    = 0;
    dims_seen     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lists. A lone dimension has no matrix at all.
    add_row(10'd5, 1'b1, 1, 1'b1, '0, '0, mcoc_pkg::StTooFew);
    // Two dimensions form a single matrix: nothing to multiply.
    add_row(10'd1023, 1'b0, 1, 1'b0, '0, '0, mcoc_pkg::StOk);
    add_row(10'd1023, 1'b1, 1, 1'b1, '0, '0, mcoc_pkg::StOk);
    // Three matrices with a zero leading dimension and field extremes.
    add_row(10'd0,    1'b0, 1, 1'b0, '0, '0, mcoc_pkg::StOk);
    add_row(10'd1023, 1'b0, 1, 1'b0, '0, '0, mcoc_pkg::StOk);
    add_row(10'd1,    1'b0, 1, 1'b0, '0, '0, mcoc_pkg::StOk);
    add_row(10'd1023, 1'b1, 1, 1'b0, '0, '0, mcoc_pkg::StOk);
    // One dimension past the limit: the extra one is dropped, the list rejected.
    add_row(10'd1023, 1'b0, DimSlots, 1'b0, '0, '0, mcoc_pkg::StOk);
    add_row(10'd0,    1'b1, 1, 1'b1, '0, '0, mcoc_pkg::StTooMany);

    for (row_idx = 0; row_idx < stim_rows.size(); row_idx++) begin
      for (rep = 0; rep < stim_rows[row_idx].reps; rep++) begin
        send_dim(stim_rows[row_idx].dim,
                 stim_rows[row_idx].last && (rep == stim_rows[row_idx].reps - 1),
                 stim_rows[row_idx].typed, stim_rows[row_idx].want);
      end
    end

    // Random lists: mostly well-formed chains with random dimensions, a few
    // lone dimensions and overlong lists.
    list_no = 0;
    while (items_sent < ItemTarget) begin
      // Hold the receiver off for a long stretch while lists keep coming, so the
      // block fills up and stalls its input.
      if (list_no == 30) sink_hold_req = 400;
      // Pause the sender until every expected result has come back.
      if (list_no == 60 || list_no == 150) begin
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      quiet = (list_no >= 90 && list_no < 115);

      r = $urandom_range(99);
      if (r < 3)       len = 1;
      else if (r < 6)  len = $urandom_range(DimSlots + 5, DimSlots + 1);
      else if (r < 9)  len = DimSlots;
      else if (r < 25) len = $urandom_range(DimSlots - 1, 9);
      else             len = $urandom_range(8, 2);

      for (i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 60)      dim = DimFieldW'($urandom);
        else if (r < 90) dim = DimFieldW'($urandom_range(16, 1));
        else if (r < 92) dim = '0;
        else if (r < 96) dim = '1;
        else             dim = 10'd1;
        send_dim(dim, i == len - 1, 1'b0, '0);
      end
      list_no++;
    end
    s_axis_tvalid <= 1'b0;

    // Drain: the watchdog catches results that never come.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
